[design/swsl_pkg.sv]
// ----------------------------------------------------------------------------
// swsl_pkg
// shared types, register indexes, reset values and codes of the send limiter
// ----------------------------------------------------------------------------
package swsl_pkg;

	localparam int DEF_QUEUE_DEPTH = 8192;
	localparam int DEF_TIME_BITS   = 48;

	localparam int NOW_W      = 48;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 20;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 8;

	localparam int COUNT_W = 14;
	localparam int GAP_W   = 16;
	localparam int SPAN_W  = 20;

	localparam logic [COUNT_W-1:0] RST_NORMAL_MAX    = 14'd19;
	localparam logic [COUNT_W-1:0] RST_ELEVATED_MAX  = 14'd99;
	localparam logic [COUNT_W-1:0] RST_BOT_MAX       = 14'd7499;
	localparam logic [GAP_W-1:0]   RST_NORMAL_GAP    = 16'd1100;
	localparam logic [GAP_W-1:0]   RST_ELEVATED_GAP  = 16'd100;
	localparam logic [SPAN_W-1:0]  RST_WINDOW        = 20'd32000;
	localparam logic [SPAN_W-1:0]  RST_WARN_HOLDOFF  = 20'd30000;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BOT_MODE,
		REG_NORMAL_MAX_COUNT,
		REG_ELEVATED_MAX_COUNT,
		REG_BOT_MAX_COUNT,
		REG_NORMAL_MIN_GAP,
		REG_ELEVATED_MIN_GAP,
		REG_WINDOW,
		REG_WARN_HOLDOFF
	} reg_index_t;

	typedef enum logic [1:0] {
		VERDICT_SENT,
		VERDICT_TOO_QUICK,
		VERDICT_TOO_MANY
	} verdict_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEWEST,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic               bot_mode;
		logic [COUNT_W-1:0] normal_max_count;
		logic [COUNT_W-1:0] elevated_max_count;
		logic [COUNT_W-1:0] bot_max_count;
		logic [GAP_W-1:0]   normal_min_gap_ms;
		logic [GAP_W-1:0]   elevated_min_gap_ms;
		logic [SPAN_W-1:0]  window_ms;
		logic [SPAN_W-1:0]  warn_holdoff_ms;
	} cfg_t;

endpackage

[design/sliding_window_send_limiter_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_send_limiter_unit
// two-class sliding window send limiter with shared refusal warnings
// ----------------------------------------------------------------------------
// Each beat on the s_ side is one send request: a millisecond time stamp in
// s_tdata and the rate class in s_tuser. Each request gives exactly one
// result beat on the m_ side: accepted, verdict and raise_warning.
// Configuration goes in through cfg_we / cfg_addr / cfg_wdata; the user
// must write it only while idle; the block itself does not enforce this.
// Both send logs share one memory with a registered read port, the class
// bit selecting the upper or lower half. On an empty log a request goes to
// the count check; else the newest entry is read and a too-quick request
// is refused, or the expiry scan pops expired head entries, one memory read
// per cycle, before the count check. s_tready is high only between
// requests, so requests are taken one at a time.
// Reset clears both logs to empty, the warning times to zero and the
// registers to their defaults; the memory needs no clearing pass since only
// entries inside the count are read.
// A stalled result waits in the output register; the next request is still
// taken and is held in its final step until the output register frees up.
// ----------------------------------------------------------------------------
module sliding_window_send_limiter_unit
	import swsl_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int TIME_BITS   = DEF_TIME_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [47:0] now_ms
	input  logic                  s_tuser,   // [0] elevated_class
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata    // [0] accepted, [2:1] verdict, [3] raise_warning
);

	localparam int AW = $clog2(QUEUE_DEPTH) + 1;

	cfg_t                 cfg;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [TIME_BITS-1:0] rd_data;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [TIME_BITS-1:0] wr_data;
	logic                 m_accepted;
	verdict_t             m_verdict;
	logic                 m_warn;

	swsl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	swsl_log_mem #(
		.ADDR_W (AW),
		.DATA_W (TIME_BITS)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	swsl_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_now      (s_tdata[NOW_W-1:0]),
		.s_cls      (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_accepted (m_accepted),
		.m_verdict  (m_verdict),
		.m_warn     (m_warn),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	assign m_tdata = {4'b0000, m_warn, m_verdict, m_accepted};

endmodule

[design/swsl_cfg_regs.sv]
// ----------------------------------------------------------------------------
// swsl_cfg_regs
// configuration register file, written by index, no read-back
// ----------------------------------------------------------------------------
module swsl_cfg_regs
	import swsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bot_mode            <= 1'b0;
			cfg_q.normal_max_count    <= RST_NORMAL_MAX;
			cfg_q.elevated_max_count  <= RST_ELEVATED_MAX;
			cfg_q.bot_max_count       <= RST_BOT_MAX;
			cfg_q.normal_min_gap_ms   <= RST_NORMAL_GAP;
			cfg_q.elevated_min_gap_ms <= RST_ELEVATED_GAP;
			cfg_q.window_ms           <= RST_WINDOW;
			cfg_q.warn_holdoff_ms     <= RST_WARN_HOLDOFF;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_addr))
				REG_BOT_MODE:           cfg_q.bot_mode <= cfg_wdata[0];
				REG_NORMAL_MAX_COUNT:   cfg_q.normal_max_count <= cfg_wdata[COUNT_W-1:0];
				REG_ELEVATED_MAX_COUNT: cfg_q.elevated_max_count <= cfg_wdata[COUNT_W-1:0];
				REG_BOT_MAX_COUNT:      cfg_q.bot_max_count <= cfg_wdata[COUNT_W-1:0];
				REG_NORMAL_MIN_GAP:     cfg_q.normal_min_gap_ms <= cfg_wdata[GAP_W-1:0];
				REG_ELEVATED_MIN_GAP:   cfg_q.elevated_min_gap_ms <= cfg_wdata[GAP_W-1:0];
				REG_WINDOW:             cfg_q.window_ms <= cfg_wdata[SPAN_W-1:0];
				REG_WARN_HOLDOFF:       cfg_q.warn_holdoff_ms <= cfg_wdata[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/swsl_log_mem.sv]
// ----------------------------------------------------------------------------
// swsl_log_mem
// send time log, one write and one registered read port
// ----------------------------------------------------------------------------
module swsl_log_mem
	import swsl_pkg::*;
#(
	parameter int ADDR_W = 14,
	parameter int DATA_W = DEF_TIME_BITS
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/swsl_ctrl.sv]
// ----------------------------------------------------------------------------
// swsl_ctrl
// request sequencer: newest-entry check, expiry scan, count check and push
// ----------------------------------------------------------------------------
module swsl_ctrl
	import swsl_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int TIME_BITS   = DEF_TIME_BITS,
	localparam int IW = $clog2(QUEUE_DEPTH),
	localparam int AW = IW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [NOW_W-1:0]     s_now,
	input  logic                 s_cls,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic                 m_accepted,
	output verdict_t             m_verdict,
	output logic                 m_warn,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	input  logic [TIME_BITS-1:0] rd_data,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic [TIME_BITS-1:0] wr_data
);

	localparam int TW = TIME_BITS;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int WW = (TW > SPAN_W) ? TW : SPAN_W;

	function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = s;
		if (s >= SW'(QUEUE_DEPTH)) begin
			r = s - SW'(QUEUE_DEPTH);
		end
		return r[IW-1:0];
	endfunction

	function automatic logic later_by_more(input logic [TW-1:0] t_now,
	                                       input logic [TW-1:0] t_then,
	                                       input logic [SPAN_W-1:0] span);
		logic [TW-1:0] diff;
		diff = t_now - t_then;
		return (t_now > t_then) && (WW'(diff) > WW'(span));
	endfunction

	state_t state_q, state_d;

	logic [TW-1:0]    now_q;
	logic             cls_q;
	logic [CW-1:0]    lim_q;
	logic [GAP_W-1:0] gap_q;
	logic [IW-1:0]    head_q [2];
	logic [CW-1:0]    cnt_q  [2];
	logic [TW-1:0]    last_quick_q;
	logic [TW-1:0]    last_many_q;
	verdict_t         res_verdict_q;
	logic             res_warn_q;
	logic             m_valid_q;
	verdict_t         m_verdict_q;
	logic             m_warn_q;

	logic [IW-1:0]      head_c;
	logic [CW-1:0]      cnt_c;
	logic               out_free;
	logic               too_quick;
	logic               expired;
	logic               quick_warn;
	logic               many_warn;
	logic               accept;
	logic [COUNT_W-1:0] lim_sel;
	logic [CW-1:0]      lim_c;
	logic [TW-1:0]      now_diff;

	logic          upd_ctl;
	logic [IW-1:0] head_n;
	logic [CW-1:0] cnt_n;
	logic          deliver;
	verdict_t      dec_verdict;
	logic          dec_warn;
	logic          load_out;
	logic          set_quick;
	logic          set_many;

	assign head_c   = head_q[cls_q];
	assign cnt_c    = cnt_q[cls_q];
	assign out_free = !m_valid_q || m_tready;
	assign accept   = (state_q == ST_IDLE) && s_tvalid;
	assign s_tready = (state_q == ST_IDLE);

	// rd_data holds the newest entry in ST_NEWEST, the head entry in ST_SCAN
	assign now_diff   = now_q - rd_data;
	assign too_quick  = (now_q < rd_data) || (WW'(now_diff) < WW'(gap_q));
	assign expired    = later_by_more(now_q, rd_data, cfg.window_ms);
	assign quick_warn = later_by_more(now_q, last_quick_q, cfg.warn_holdoff_ms);
	assign many_warn  = later_by_more(now_q, last_many_q, cfg.warn_holdoff_ms);

	assign lim_sel = cfg.bot_mode ? cfg.bot_max_count
	               : (s_cls ? cfg.elevated_max_count : cfg.normal_max_count);
	assign lim_c   = (32'(lim_sel) > 32'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(lim_sel);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (cnt_q[s_cls] == '0) ? ST_DECIDE : ST_NEWEST;
				end
			end
			ST_NEWEST: begin
				if (!too_quick) begin
					state_d = ST_SCAN;
				end else begin
					state_d = out_free ? ST_IDLE : ST_EMIT;
				end
			end
			ST_SCAN: begin
				// one expired entry popped per cycle
				if (!(expired && (cnt_c != CW'(1)))) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: state_d = out_free ? ST_IDLE : ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = now_q;
		upd_ctl     = 1'b0;
		head_n      = head_c;
		cnt_n       = cnt_c;
		deliver     = 1'b0;
		dec_verdict = VERDICT_SENT;
		dec_warn    = 1'b0;
		load_out    = 1'b0;
		set_quick   = 1'b0;
		set_many    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_en   = accept && (cnt_q[s_cls] != '0);
				rd_addr = {s_cls, wrap_idx(SW'(head_q[s_cls]) + SW'(cnt_q[s_cls]) - SW'(1))};
			end
			ST_NEWEST: begin
				if (too_quick) begin
					deliver     = 1'b1;
					dec_verdict = VERDICT_TOO_QUICK;
					dec_warn    = quick_warn;
					set_quick   = quick_warn;
				end else begin
					rd_en   = 1'b1;
					rd_addr = {cls_q, head_c};
				end
			end
			ST_SCAN: begin
				if (expired) begin
					upd_ctl = 1'b1;
					head_n  = wrap_idx(SW'(head_c) + SW'(1));
					cnt_n   = cnt_c - CW'(1);
					rd_en   = (cnt_n != '0);
					rd_addr = {cls_q, head_n};
				end
			end
			ST_DECIDE: begin
				deliver = 1'b1;
				if (cnt_c >= lim_q) begin
					dec_verdict = VERDICT_TOO_MANY;
					dec_warn    = many_warn;
					set_many    = many_warn;
				end else begin
					wr_en   = 1'b1;
					wr_addr = {cls_q, wrap_idx(SW'(head_c) + SW'(cnt_c))};
					upd_ctl = 1'b1;
					cnt_n   = cnt_c + CW'(1);
				end
			end
			ST_EMIT: begin
				load_out    = out_free;
				dec_verdict = res_verdict_q;
				dec_warn    = res_warn_q;
			end
			default: ;
		endcase
		if (deliver) begin
			load_out = out_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q[0]    <= '0;
			head_q[1]    <= '0;
			cnt_q[0]     <= '0;
			cnt_q[1]     <= '0;
			last_quick_q <= '0;
			last_many_q  <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (upd_ctl) begin
				head_q[cls_q] <= head_n;
				cnt_q[cls_q]  <= cnt_n;
			end
			if (set_quick) begin
				last_quick_q <= now_q;
			end
			if (set_many) begin
				last_many_q <= now_q;
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= TW'(s_now);
			cls_q <= s_cls;
			lim_q <= lim_c;
			gap_q <= s_cls ? cfg.elevated_min_gap_ms : cfg.normal_min_gap_ms;
		end
		if (deliver && !out_free) begin
			res_verdict_q <= dec_verdict;
			res_warn_q    <= dec_warn;
		end
		if (load_out) begin
			m_verdict_q <= dec_verdict;
			m_warn_q    <= dec_warn;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_verdict  = m_verdict_q;
	assign m_warn     = m_warn_q;
	assign m_accepted = (m_verdict_q == VERDICT_SENT);

endmodule

[design/swsl_checker.sv]
// ----------------------------------------------------------------------------
// swsl_checker
// port-level checks of the send limiter, bound to the top level
// ----------------------------------------------------------------------------
module swsl_checker
	import swsl_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one request at a time: ready drops after an accepted beat
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// accepted flag agrees with the verdict code
	a_accept_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == VERDICT_SENT)))
		else $error("accepted flag and verdict disagree");

	// no warning on a sent request, no unused verdict code
	a_warn_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[3]) && (m_tdata[2:1] != 2'b11))
		else $error("warning on sent request or bad verdict");

endmodule

bind sliding_window_send_limiter_unit swsl_checker u_swsl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
